@@ rtl/rhc_pkg.sv @@
// rhc_pkg: shared constants, types and queue entry format of the rgb/hsv converter
`default_nettype none
package rhc_pkg;
    // field formats
    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 4;
    localparam int HUE_BITS      = HUE_FRAC_BITS + 9;
    localparam int SEC_BITS      = HUE_FRAC_BITS + 6;
    localparam int SECTOR_BITS   = 3;
    localparam int NUM_BITS      = CHANNEL_BITS + 3;
    localparam int PROD_BITS     = CHANNEL_BITS + SEC_BITS;
    localparam int DIVIDEND_BITS = CHANNEL_BITS + PROD_BITS;
    localparam int QUOT_BITS     = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    // arithmetic constants
    localparam int CMAX     = (1 << CHANNEL_BITS) - 1;
    localparam int SEC      = 60 << HUE_FRAC_BITS;
    localparam int HFULL    = 6 * SEC;
    localparam int SEC_DEN  = CMAX * SEC;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_TO_HSV = 1'b0,
        OP_TO_RGB = 1'b1
    } op_t;

    // classified transaction as held in the queue
    typedef struct packed {
        op_t                      op;
        logic [CHANNEL_BITS-1:0]  red;
        logic [CHANNEL_BITS-1:0]  green;
        logic [CHANNEL_BITS-1:0]  blue;
        logic [CHANNEL_BITS-1:0]  sat;
        logic [CHANNEL_BITS-1:0]  val;
        logic [CHANNEL_BITS-1:0]  spread;
        logic [HUE_BITS-1:0]      hue;
        logic                     hue_und;
        logic                     grey;
        logic [SECTOR_BITS-1:0]   sector;
        logic [NUM_BITS-1:0]      num;
        logic [PROD_BITS-1:0]     s_fr;
        logic [PROD_BITS-1:0]     s_fr_c;
    } item_t;
endpackage
`default_nettype wire

@@ rtl/rhc_front.sv @@
// rhc_front: classifies an incoming pixel (max/min, hue sector, products for the back end)
`default_nettype none
module rhc_front (
    input  wire rhc_pkg::op_t                        operation,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    in_red,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    in_green,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    in_blue,
    input  wire logic [rhc_pkg::HUE_BITS-1:0]        in_hue,
    input  wire logic                                in_hue_undefined,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    in_saturation,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    in_value,
    output rhc_pkg::item_t                           item
);
    localparam int CB = rhc_pkg::CHANNEL_BITS;
    localparam int HB = rhc_pkg::HUE_BITS;
    localparam int WB = CB + 4;

    logic [CB-1:0]                   mx;
    logic [CB-1:0]                   mn;
    logic [CB-1:0]                   d;
    logic [WB-1:0]                   num_w;
    logic [HB-1:0]                   h_eff;
    logic [rhc_pkg::SECTOR_BITS-1:0] sector;
    logic [HB-1:0]                   fr_w;
    logic [rhc_pkg::SEC_BITS-1:0]    fr;
    logic [rhc_pkg::SEC_BITS-1:0]    fr_c;

    // max, min and spread
    always_comb begin
        mx = in_red;
        mn = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue > mx) mx = in_blue;
        if (in_green < mn) mn = in_green;
        if (in_blue < mn) mn = in_blue;
        d = mx - mn;
    end

    // hue numerator, sector chosen by the largest channel
    always_comb begin
        if (in_green == mx) begin
            num_w = (WB'(d) << 1) + WB'(in_blue) - WB'(in_red);
        end else if (in_blue == mx) begin
            num_w = (WB'(d) << 2) + WB'(in_red) - WB'(in_green);
        end else if (in_green < in_blue) begin
            num_w = WB'(6) * WB'(d) + WB'(in_green) - WB'(in_blue);
        end else begin
            num_w = WB'(in_green) - WB'(in_blue);
        end
    end

    // effective hue, sector and position within the sector
    always_comb begin
        h_eff = ((in_hue >= HB'(rhc_pkg::HFULL)) || in_hue_undefined) ? '0 : in_hue;
        sector = '0;
        for (int k = 1; k < 6; k++) begin
            if (h_eff >= HB'(k * rhc_pkg::SEC)) sector = rhc_pkg::SECTOR_BITS'(k);
        end
        fr_w = h_eff - HB'(32'(sector) * rhc_pkg::SEC);
        fr   = fr_w[rhc_pkg::SEC_BITS-1:0];
        fr_c = rhc_pkg::SEC_BITS'(rhc_pkg::SEC) - fr;
    end

    // queue entry
    always_comb begin
        item.op      = operation;
        item.red     = in_red;
        item.green   = in_green;
        item.blue    = in_blue;
        item.sat     = in_saturation;
        item.val     = (operation == rhc_pkg::OP_TO_HSV) ? mx : in_value;
        item.spread  = d;
        item.hue     = h_eff;
        item.hue_und = (operation == rhc_pkg::OP_TO_HSV) ? (d == '0) : in_hue_undefined;
        item.grey    = (in_saturation == '0) || in_hue_undefined;
        item.sector  = sector;
        item.num     = num_w[rhc_pkg::NUM_BITS-1:0];
        item.s_fr    = rhc_pkg::PROD_BITS'(in_saturation) * rhc_pkg::PROD_BITS'(fr);
        item.s_fr_c  = rhc_pkg::PROD_BITS'(in_saturation) * rhc_pkg::PROD_BITS'(fr_c);
    end
endmodule
`default_nettype wire

@@ rtl/rhc_fifo.sv @@
// rhc_fifo: short queue of classified transactions between front and back
`default_nettype none
module rhc_fifo #(
    parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rhc_pkg::item_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output rhc_pkg::item_t       pop_data,
    output logic                 empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rhc_pkg::item_t mem_reg [0:DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop) rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("queue read while empty");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
endmodule
`default_nettype wire

@@ rtl/rhc_div.sv @@
// rhc_div: pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rhc_div #(
    parameter int NW = rhc_pkg::DIVIDEND_BITS,
    parameter int DW = rhc_pkg::PROD_BITS,
    parameter int QW = rhc_pkg::QUOT_BITS
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [QW-1:0] quotient
);
    localparam int SW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] quo_cur;
        logic [SW-1:0] sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_cur = dividend;
            assign den_cur = divisor;
            assign quo_cur = '0;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign quo_cur = quo_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign sub = SW'(den_cur) << B;
        assign ge  = (SW'(rem_cur) >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? NW'(SW'(rem_cur) - sub) : rem_cur;
                den_reg[k] <= den_cur;
                quo_reg[k] <= {quo_cur[QW-2:0], ge};
            end
        end
    end

    assign quotient = quo_reg[QW-1];
endmodule
`default_nettype wire

@@ rtl/rhc_back.sv @@
// rhc_back: operand set-up, two shared dividers and result assembly
`default_nettype none
module rhc_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire rhc_pkg::item_t                     in_item,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_red,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_green,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_blue,
    output logic [rhc_pkg::HUE_BITS-1:0]            m_out_hue,
    output logic                                    m_out_hue_undefined,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_saturation,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_value
);
    localparam int CB = rhc_pkg::CHANNEL_BITS;
    localparam int HB = rhc_pkg::HUE_BITS;
    localparam int NW = rhc_pkg::DIVIDEND_BITS;
    localparam int DW = rhc_pkg::PROD_BITS;
    localparam int QW = rhc_pkg::QUOT_BITS;
    localparam int PW = 2 * CB;

    logic           en;
    logic           setup_valid_reg;
    rhc_pkg::item_t setup_item_reg;
    logic [NW-1:0]  dvd_reg [0:1];
    logic [DW-1:0]  dvs_reg [0:1];
    logic [NW-1:0]  dvd_next [0:1];
    logic [DW-1:0]  dvs_next [0:1];
    logic [QW-1:0]  quo [0:1];
    logic [PW-1:0]  p_prod;
    logic [PW-1:0]  p_sum;
    logic [CB-1:0]  p_next;
    logic [CB-1:0]  p_setup_reg;
    logic [CB-1:0]  p_div_reg [0:QW-1];
    logic           div_valid_reg [0:QW-1];
    rhc_pkg::item_t div_item_reg [0:QW-1];
    rhc_pkg::item_t last_item;
    logic           out_valid_reg;
    rhc_pkg::item_t out_item_reg;
    logic [CB-1:0]  red_reg, green_reg, blue_reg, sat_reg, val_reg;
    logic [CB-1:0]  red_next, green_next, blue_next, sat_next, val_next;
    logic [HB-1:0]  hue_reg, hue_next;
    logic           und_reg, und_next;
    logic [CB-1:0]  p, q, t;

    // whole pipeline moves unless the result register is stalled
    assign en       = !out_valid_reg || m_ready;
    assign in_ready = en;

    // divider operands: hue or q, and saturation or t
    always_comb begin
        if (in_item.op == rhc_pkg::OP_TO_HSV) begin
            dvd_next[0] = NW'(rhc_pkg::SEC) * NW'(in_item.num);
            dvs_next[0] = (in_item.spread == '0) ? DW'(1) : DW'(in_item.spread);
            dvd_next[1] = NW'(rhc_pkg::CMAX) * NW'(in_item.spread);
            dvs_next[1] = (in_item.val == '0) ? DW'(1) : DW'(in_item.val);
        end else begin
            dvd_next[0] = NW'(in_item.val) * NW'(DW'(rhc_pkg::SEC_DEN) - in_item.s_fr);
            dvs_next[0] = DW'(rhc_pkg::SEC_DEN);
            dvd_next[1] = NW'(in_item.val) * NW'(DW'(rhc_pkg::SEC_DEN) - in_item.s_fr_c);
            dvs_next[1] = DW'(rhc_pkg::SEC_DEN);
        end
    end

    // p divides by cmax: (x + (x >> CB) + 1) >> CB is exact for x up to cmax squared
    always_comb begin
        p_prod = PW'(in_item.val) * PW'(CB'(rhc_pkg::CMAX) - in_item.sat);
        p_sum  = p_prod + (p_prod >> CB) + PW'(1);
        p_next = p_sum[PW-1:CB];
    end

    // operand set-up stage
    always_ff @(posedge aclk) begin
        if (en) begin
            setup_item_reg <= in_item;
            p_setup_reg    <= p_next;
            for (int i = 0; i < 2; i++) begin
                dvd_reg[i] <= dvd_next[i];
                dvs_reg[i] <= dvs_next[i];
            end
        end
    end

    for (genvar i = 0; i < 2; i++) begin : g_div
        rhc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
            .aclk     (aclk),
            .en       (en),
            .dividend (dvd_reg[i]),
            .divisor  (dvs_reg[i]),
            .quotient (quo[i])
        );
    end

    // side data travelling with the dividers
    always_ff @(posedge aclk) begin
        if (en) begin
            div_item_reg[0] <= setup_item_reg;
            p_div_reg[0]    <= p_setup_reg;
            for (int k = 1; k < QW; k++) begin
                div_item_reg[k] <= div_item_reg[k-1];
                p_div_reg[k]    <= p_div_reg[k-1];
            end
        end
    end

    // valid bits of every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_valid_reg <= 1'b0;
            for (int k = 0; k < QW; k++) div_valid_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            setup_valid_reg  <= in_valid;
            div_valid_reg[0] <= setup_valid_reg;
            for (int k = 1; k < QW; k++) div_valid_reg[k] <= div_valid_reg[k-1];
            out_valid_reg <= div_valid_reg[QW-1];
        end
    end

    // result assembly
    assign last_item = div_item_reg[QW-1];
    assign q = quo[0][CB-1:0];
    assign t = quo[1][CB-1:0];
    assign p = p_div_reg[QW-1];

    always_comb begin
        red_next   = last_item.red;
        green_next = last_item.green;
        blue_next  = last_item.blue;
        hue_next   = last_item.hue;
        und_next   = last_item.hue_und;
        sat_next   = last_item.sat;
        val_next   = last_item.val;
        if (last_item.op == rhc_pkg::OP_TO_HSV) begin
            hue_next = last_item.hue_und ? '0 : quo[0][HB-1:0];
            sat_next = quo[1][CB-1:0];
        end else if (last_item.grey) begin
            red_next   = last_item.val;
            green_next = last_item.val;
            blue_next  = last_item.val;
        end else begin
            case (last_item.sector)
                3'd0: begin red_next = last_item.val; green_next = t; blue_next = p; end
                3'd1: begin red_next = q; green_next = last_item.val; blue_next = p; end
                3'd2: begin red_next = p; green_next = last_item.val; blue_next = t; end
                3'd3: begin red_next = p; green_next = q; blue_next = last_item.val; end
                3'd4: begin red_next = t; green_next = p; blue_next = last_item.val; end
                default: begin red_next = last_item.val; green_next = p; blue_next = q; end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (en) begin
            out_item_reg <= last_item;
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            hue_reg      <= hue_next;
            und_reg      <= und_next;
            sat_reg      <= sat_next;
            val_reg      <= val_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_out_red           = red_reg;
    assign m_out_green         = green_reg;
    assign m_out_blue          = blue_reg;
    assign m_out_hue           = hue_reg;
    assign m_out_hue_undefined = und_reg;
    assign m_out_saturation    = sat_reg;
    assign m_out_value         = val_reg;

    a_grey_hue_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_item_reg.op == rhc_pkg::OP_TO_HSV && und_reg |-> hue_reg == '0)
        else $error("undefined hue not cleared");
    a_hue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> hue_reg < HB'(rhc_pkg::HFULL))
        else $error("hue result out of range");
    a_grey_channels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_item_reg.op == rhc_pkg::OP_TO_RGB && out_item_reg.grey
        |-> red_reg == val_reg && green_reg == val_reg && blue_reg == val_reg)
        else $error("achromatic request gave unequal channels");
endmodule
`default_nettype wire

@@ rtl/rgb_hsv_color_converter.sv @@
// rgb_hsv_color_converter: per-pixel rgb to hsv and hsv to rgb converter, top level
//
//   channel  | ports             | direction | content
//   ---------+-------------------+-----------+--------------------------------------
//   s_       | s_valid / s_ready | in        | operation, rgb and hsv fields
//   m_       | m_valid / m_ready | out       | converted rgb and hsv fields
//
// one transaction per cycle sustained unless the receiver stalls the result register;
// operands are registered, then pipelined dividers produce one quotient bit per stage
// the front classifies into a queue of QUEUE_DEPTH entries; the back stalls as a whole
// only when its result register holds an untaken transaction
// synchronous active-low reset clears the queue and all stage valid bits
`default_nettype none
module rgb_hsv_color_converter #(
    parameter int QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]   s_in_red,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]   s_in_green,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]   s_in_blue,
    input  wire logic [rhc_pkg::HUE_BITS-1:0]       s_in_hue,
    input  wire logic                               s_in_hue_undefined,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]   s_in_saturation,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]   s_in_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_red,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_green,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_blue,
    output logic [rhc_pkg::HUE_BITS-1:0]            m_out_hue,
    output logic                                    m_out_hue_undefined,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_saturation,
    output logic [rhc_pkg::CHANNEL_BITS-1:0]        m_out_value
);
    rhc_pkg::item_t front_item;
    rhc_pkg::item_t head_item;
    rhc_pkg::op_t   op;
    logic           full;
    logic           empty;
    logic           back_ready;

    assign op      = rhc_pkg::op_t'(s_operation);
    assign s_ready = !full;

    // classification
    rhc_front u_front (
        .operation        (op),
        .in_red           (s_in_red),
        .in_green         (s_in_green),
        .in_blue          (s_in_blue),
        .in_hue           (s_in_hue),
        .in_hue_undefined (s_in_hue_undefined),
        .in_saturation    (s_in_saturation),
        .in_value         (s_in_value),
        .item             (front_item)
    );

    // queue between front and back
    rhc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && !full),
        .push_data (front_item),
        .full      (full),
        .pop       (back_ready && !empty),
        .pop_data  (head_item),
        .empty     (empty)
    );

    // divisions and result assembly
    rhc_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (!empty),
        .in_ready            (back_ready),
        .in_item             (head_item),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_red           (m_out_red),
        .m_out_green         (m_out_green),
        .m_out_blue          (m_out_blue),
        .m_out_hue           (m_out_hue),
        .m_out_hue_undefined (m_out_hue_undefined),
        .m_out_saturation    (m_out_saturation),
        .m_out_value         (m_out_value)
    );
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking testbench of the rgb/hsv colour converter
`default_nettype none
module tb_top;
    import rhc_pkg::*;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [HUE_BITS-1:0]     hue;
        logic                    hue_und;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
    } pixel_t;

    typedef struct packed {
        op_t    op;
        pixel_t px;
    } pixel_req_t;

    // directed row: request, and a typed-in answer where it is obvious
    typedef struct packed {
        pixel_req_t req;
        logic       known;
        pixel_t     answer;
    } dir_row_t;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = 1'b0;
    logic [CHANNEL_BITS-1:0] s_in_red = '0, s_in_green = '0, s_in_blue = '0;
    logic [HUE_BITS-1:0] s_in_hue = '0;
    logic s_in_hue_undefined = 1'b0;
    logic [CHANNEL_BITS-1:0] s_in_saturation = '0, s_in_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CHANNEL_BITS-1:0] m_out_red, m_out_green, m_out_blue;
    logic [HUE_BITS-1:0] m_out_hue;
    logic m_out_hue_undefined;
    logic [CHANNEL_BITS-1:0] m_out_saturation, m_out_value;

    pixel_t converted_q[$];
    int mismatches = 0;
    int checked = 0;
    int cycle_count = 0;
    int n_hsv = 0, n_rgb = 0;
    int sender_idle = 0, receiver_idle = 0;

    always #1 aclk = ~aclk;

    rgb_hsv_color_converter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_in_red(s_in_red), .s_in_green(s_in_green),
        .s_in_blue(s_in_blue), .s_in_hue(s_in_hue),
        .s_in_hue_undefined(s_in_hue_undefined),
        .s_in_saturation(s_in_saturation), .s_in_value(s_in_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green), .m_out_blue(m_out_blue),
        .m_out_hue(m_out_hue), .m_out_hue_undefined(m_out_hue_undefined),
        .m_out_saturation(m_out_saturation), .m_out_value(m_out_value)
    );

    // rgb to hsv, all results truncated
    function automatic pixel_t rgb_to_hsv(pixel_t px);
        pixel_t o;
        longint unsigned r, g, b, mx, mn, d, num;
        r = px.red; g = px.green; b = px.blue;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        o = '0;
        o.red = px.red; o.green = px.green; o.blue = px.blue;
        if (d != 0) begin
            if (g == mx) num = 2 * d + b - r;
            else if (b == mx) num = 4 * d + r - g;
            else if (g < b) num = 6 * d + g - b;
            else num = g - b;
            o.hue = HUE_BITS'((SEC * num) / d);
        end else begin
            o.hue_und = 1'b1;
        end
        if (mx != 0) o.sat = CHANNEL_BITS'((CMAX * d) / mx);
        o.val = CHANNEL_BITS'(mx);
        return o;
    endfunction

    // hsv to rgb, six sectors with p, q and t
    function automatic pixel_t hsv_to_rgb(pixel_t px);
        pixel_t o;
        longint unsigned h, s, v, i, fr, den, p, q, t, r, g, b;
        s = px.sat; v = px.val;
        h = (px.hue >= HFULL || px.hue_und) ? 0 : px.hue;
        if (s == 0 || px.hue_und) begin
            r = v; g = v; b = v;
        end else begin
            i = h / SEC; fr = h % SEC; den = CMAX * SEC;
            p = (v * (CMAX - s)) / CMAX;
            q = (v * (den - s * fr)) / den;
            t = (v * (den - s * (SEC - fr))) / den;
            case (i)
                0: begin r = v; g = t; b = p; end
                1: begin r = q; g = v; b = p; end
                2: begin r = p; g = v; b = t; end
                3: begin r = p; g = q; b = v; end
                4: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
        end
        o.red = CHANNEL_BITS'(r); o.green = CHANNEL_BITS'(g); o.blue = CHANNEL_BITS'(b);
        o.hue = HUE_BITS'(h);
        o.hue_und = px.hue_und;
        o.sat = px.sat; o.val = px.val;
        return o;
    endfunction

    function automatic pixel_t convert_pixel(pixel_req_t req);
        return (req.op == OP_TO_HSV) ? rgb_to_hsv(req.px) : hsv_to_rgb(req.px);
    endfunction

    function automatic pixel_req_t random_pixel(op_t op);
        pixel_req_t req;
        req.op = op;
        req.px.red = CHANNEL_BITS'($urandom);
        req.px.green = CHANNEL_BITS'($urandom);
        req.px.blue = CHANNEL_BITS'($urandom);
        req.px.hue = ($urandom_range(0, 7) == 0) ? HUE_BITS'($urandom)
                                                  : HUE_BITS'($urandom_range(0, HFULL - 1));
        req.px.hue_und = ($urandom_range(0, 9) == 0);
        req.px.sat = CHANNEL_BITS'($urandom);
        req.px.val = CHANNEL_BITS'($urandom);
        // grey and near-grey pixels now and then
        if ($urandom_range(0, 7) == 0) begin
            req.px.green = req.px.red;
            req.px.blue = ($urandom_range(0, 1) == 1) ? req.px.red : req.px.blue;
        end
        if ($urandom_range(0, 9) == 0) req.px.sat = '0;
        return req;
    endfunction

    // present one transaction and hold it until accepted; valid drops only while idling
    task automatic send_pixel(pixel_req_t req, logic known, pixel_t answer);
        while (($urandom_range(0, 99)) < sender_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= req.op;
        s_in_red <= req.px.red; s_in_green <= req.px.green; s_in_blue <= req.px.blue;
        s_in_hue <= req.px.hue; s_in_hue_undefined <= req.px.hue_und;
        s_in_saturation <= req.px.sat; s_in_value <= req.px.val;
        do @(posedge aclk); while (!s_ready);
        converted_q.push_back(known ? answer : convert_pixel(req));
        if (req.op == OP_TO_HSV) n_hsv++; else n_rgb++;
        @(negedge aclk);
    endtask

    // receiver readiness
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        pixel_t got, exp_px;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_red, m_out_green, m_out_blue, m_out_hue, m_out_hue_undefined,
                    m_out_saturation, m_out_value};
            if (converted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %p", got);
            end else begin
                exp_px = converted_q.pop_front();
                checked++;
                if (got !== exp_px) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_px, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout with %0d transactions outstanding", converted_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic dir_row_t row(op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [HUE_BITS-1:0] h, logic u, logic [7:0] s,
                                     logic [7:0] v, logic known, pixel_t answer);
        dir_row_t d;
        d.req.op = op;
        d.req.px = '{r, g, b, h, u, s, v};
        d.known = known;
        d.answer = answer;
        return d;
    endfunction

    dir_row_t directed[$];

    initial begin
        int phase;
        // extremes, grey, each dominant channel, each sector, wrap and undefined hue
        directed.push_back(row(OP_TO_HSV, 0, 0, 0, 0, 0, 0, 0, 1,
                               '{8'd0, 8'd0, 8'd0, 13'd0, 1'b1, 8'd0, 8'd0}));
        directed.push_back(row(OP_TO_HSV, 255, 255, 255, 8191, 1, 255, 255, 1,
                               '{8'd255, 8'd255, 8'd255, 13'd0, 1'b1, 8'd0, 8'd255}));
        directed.push_back(row(OP_TO_HSV, 255, 0, 0, 0, 0, 0, 0, 1,
                               '{8'd255, 8'd0, 8'd0, 13'd0, 1'b0, 8'd255, 8'd255}));
        directed.push_back(row(OP_TO_HSV, 0, 255, 0, 0, 0, 0, 0, 1,
                               '{8'd0, 8'd255, 8'd0, 13'd1920, 1'b0, 8'd255, 8'd255}));
        directed.push_back(row(OP_TO_HSV, 0, 0, 255, 0, 0, 0, 0, 1,
                               '{8'd0, 8'd0, 8'd255, 13'd3840, 1'b0, 8'd255, 8'd255}));
        directed.push_back(row(OP_TO_HSV, 200, 10, 90, 0, 0, 0, 0, 0, '0));
        directed.push_back(row(OP_TO_HSV, 200, 90, 10, 0, 0, 0, 0, 0, '0));
        directed.push_back(row(OP_TO_HSV, 255, 255, 0, 0, 0, 0, 0, 0, '0));
        directed.push_back(row(OP_TO_HSV, 255, 0, 255, 0, 0, 0, 0, 0, '0));
        directed.push_back(row(OP_TO_HSV, 1, 0, 0, 0, 0, 0, 0, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 100, 0, 0, 77, 1,
                               '{8'd77, 8'd77, 8'd77, 13'd100, 1'b0, 8'd0, 8'd77}));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 2000, 1, 200, 99, 1,
                               '{8'd99, 8'd99, 8'd99, 13'd0, 1'b1, 8'd200, 8'd99}));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 0, 0, 255, 255, 1,
                               '{8'd255, 8'd0, 8'd0, 13'd0, 1'b0, 8'd255, 8'd255}));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 5760, 0, 255, 255, 1,
                               '{8'd255, 8'd0, 8'd0, 13'd0, 1'b0, 8'd255, 8'd255}));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 8191, 0, 128, 200, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 5759, 0, 255, 255, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 500, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 1400, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 2400, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 3300, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 4200, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 5100, 0, 180, 220, 0, '0));
        directed.push_back(row(OP_TO_RGB, 0, 0, 0, 959, 0, 1, 255, 0, '0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // three idling phases, directed rows in the first
        for (phase = 0; phase < 3; phase++) begin
            sender_idle = (phase == 0) ? 19 : (phase == 1) ? 58 : 0;
            receiver_idle = (phase == 0) ? 58 : (phase == 1) ? 19 : 0;
            if (phase == 0)
                foreach (directed[i]) send_pixel(directed[i].req, directed[i].known,
                                                 directed[i].answer);
            for (int n = 0; n < 260; n++) begin
                send_pixel(random_pixel(op_t'($urandom_range(0, 1))), 1'b0, '0);
                // sender holds off until the pipeline has fully drained
                if (phase == 0 && n == 100) begin
                    s_valid <= 1'b0;
                    while (converted_q.size() != 0) @(negedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        while (converted_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("covered %0d rgb-to-hsv and %0d hsv-to-rgb transactions, %0d checked",
                 n_hsv, n_rgb, checked);
        if (mismatches == 0 && converted_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_fifo.sv
rtl/rhc_div.sv
rtl/rhc_back.sv
rtl/rgb_hsv_color_converter.sv
test/tb_top.sv
